### rtl/tagged_stack_alu_defines.svh
// assertion macros for the tagged stack alu checker
`ifndef TAGGED_STACK_ALU_DEFINES_SVH
`define TAGGED_STACK_ALU_DEFINES_SVH

// same-cycle implication
`define TSA_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tagged_stack_alu: port check failed");

// next-cycle implication
`define TSA_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tagged_stack_alu: port sequence check failed");

`endif

### rtl/tsa_pkg.sv
package tsa_pkg;

	// opcodes
	localparam logic [3:0] OP_PUSH = 4'd0;
	localparam logic [3:0] OP_POP  = 4'd1;
	localparam logic [3:0] OP_ADD  = 4'd2;
	localparam logic [3:0] OP_SUB  = 4'd3;
	localparam logic [3:0] OP_MUL  = 4'd4;
	localparam logic [3:0] OP_DIV  = 4'd5;
	localparam logic [3:0] OP_REM  = 4'd6;
	localparam logic [3:0] OP_POW  = 4'd7;
	localparam logic [3:0] OP_LT   = 4'd8;
	localparam logic [3:0] OP_LE   = 4'd9;
	localparam logic [3:0] OP_EQ   = 4'd10;
	localparam logic [3:0] OP_NE   = 4'd11;
	localparam logic [3:0] OP_GE   = 4'd12;
	localparam logic [3:0] OP_GT   = 4'd13;

	// error codes
	localparam logic [2:0] ERR_OK    = 3'd0;
	localparam logic [2:0] ERR_FULL  = 3'd1;
	localparam logic [2:0] ERR_FEW   = 3'd2;
	localparam logic [2:0] ERR_TYPE  = 3'd3;
	localparam logic [2:0] ERR_DIVZ  = 3'd4;
	localparam logic [2:0] ERR_BADOP = 3'd5;

	// type tags
	localparam logic [1:0] TAG_NONE = 2'd0;
	localparam logic [1:0] TAG_INT  = 2'd1;
	localparam logic [1:0] TAG_BOOL = 2'd3;

	typedef struct packed {
		logic [3:0]         opcode;
		logic signed [63:0] push_value;
		logic [1:0]         push_tag;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         error_code;
		logic signed [63:0] top_value;
		logic [1:0]         top_tag;
		logic [6:0]         stack_depth;
	} out_item_t;

	typedef enum logic [2:0] {
		CLS_PUSH,
		CLS_POP,
		CLS_ARITH,
		CLS_CMP,
		CLS_BAD
	} op_class_t;

	// classified operation handed from front to back
	typedef struct packed {
		op_class_t   cls;
		logic [3:0]  opcode;
		logic [63:0] value;
		logic [1:0]  tag;
	} dec_item_t;

	typedef struct packed {
		logic [1:0]  tag;
		logic [63:0] value;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ITER,
		ST_FIN
	} bk_state_t;

endpackage

### rtl/tsa_front.sv
module tsa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tsa_pkg::in_item_t   in_item,
	output logic                q_valid,
	output tsa_pkg::dec_item_t  q_item,
	input  logic                q_pop
);
	import tsa_pkg::*;

	dec_item_t slot_q [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] fill_q;
	logic      push_beat;
	dec_item_t dec;

	// classify the incoming operation
	always_comb begin
		dec.opcode = in_item.opcode;
		dec.value  = in_item.push_value;
		dec.tag    = in_item.push_tag;
		if (in_item.opcode == OP_PUSH) begin
			dec.cls = CLS_PUSH;
		end else if (in_item.opcode == OP_POP) begin
			dec.cls = CLS_POP;
		end else if (in_item.opcode inside {[OP_ADD:OP_POW]}) begin
			dec.cls = CLS_ARITH;
		end else if (in_item.opcode inside {[OP_LT:OP_GT]}) begin
			dec.cls = CLS_CMP;
		end else begin
			dec.cls = CLS_BAD;
		end
	end

	assign busy      = (fill_q == 2'd2);
	assign push_beat = start && !busy;
	assign q_valid   = (fill_q != 2'd0);
	assign q_item    = slot_q[rd_ptr_q];

	// two-slot queue storage
	always_ff @(posedge clk) begin
		if (push_beat) slot_q[wr_ptr_q] <= dec;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push_beat) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + 2'(push_beat) - 2'(q_pop);
		end
	end

endmodule

### rtl/tsa_back.sv
module tsa_back #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  tsa_pkg::dec_item_t  q_item,
	output logic                q_pop,
	output logic                done,
	output tsa_pkg::out_item_t  result
);
	import tsa_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// stack storage
	entry_t            mem [STACK_DEPTH];
	entry_t            rd_top_q, rd_sec_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	entry_t            mem_wdata;

	bk_state_t         state_q, state_nxt;
	dec_item_t         cur_q;
	logic [CW-1:0]     cnt_q, cnt_m1, cnt_m2;

	// iteration registers
	logic [63:0]       a_q, b_q, acc_q, ex_q;
	logic [5:0]        it_q;
	logic              sa_q, sb_q;
	logic              iter_last;

	// check results
	logic [2:0]        chk_err;
	logic              chk_iter, chk_wr;
	logic [63:0]       chk_val;
	logic [1:0]        chk_tag;
	logic [CW-1:0]     chk_cnt;
	logic [AW-1:0]     chk_waddr;

	// emit controls
	logic              emit;
	logic [2:0]        emit_err;
	logic [63:0]       emit_val;
	logic [1:0]        emit_tag;
	logic [CW-1:0]     emit_cnt;
	logic [63:0]       fin_val;

	logic done_q;
	out_item_t result_q;

	logic [63:0] lv, rv, ua, ub;
	logic [1:0]  lt, rt;
	logic [64:0] trial;
	logic [31:0] pw_acc, pw_sq;

	assign cnt_m1 = cnt_q - CW'(1);
	assign cnt_m2 = cnt_q - CW'(2);
	assign lv = rd_sec_q.value;
	assign rv = rd_top_q.value;
	assign lt = rd_sec_q.tag;
	assign rt = rd_top_q.tag;
	assign ua = lv[63] ? (64'd0 - lv) : lv;
	assign ub = rv[63] ? (64'd0 - rv) : rv;

	// memory write and registered reads of the two top entries
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_top_q <= mem[cnt_m1[AW-1:0]];
		rd_sec_q <= mem[cnt_m2[AW-1:0]];
	end

	// operand checks and single-step results
	always_comb begin
		chk_err   = ERR_OK;
		chk_iter  = 1'b0;
		chk_wr    = 1'b0;
		chk_val   = 64'd0;
		chk_tag   = TAG_NONE;
		chk_cnt   = cnt_q;
		chk_waddr = cnt_m2[AW-1:0];
		case (cur_q.cls)
			CLS_PUSH: begin
				if (cnt_q >= CW'(STACK_DEPTH)) begin
					chk_err = ERR_FULL;
				end else if (!(cur_q.tag == TAG_INT || cur_q.tag == TAG_BOOL)) begin
					chk_err = ERR_TYPE;
				end else begin
					chk_wr    = 1'b1;
					chk_waddr = cnt_q[AW-1:0];
					chk_val   = cur_q.value;
					chk_tag   = cur_q.tag;
					chk_cnt   = cnt_q + CW'(1);
				end
			end
			CLS_POP: begin
				if (cnt_q == '0) begin
					chk_err = ERR_FEW;
				end else begin
					chk_val = rv;
					chk_tag = rt;
					chk_cnt = cnt_m1;
				end
			end
			CLS_ARITH: begin
				if (cnt_q < CW'(2)) begin
					chk_err = ERR_FEW;
				end else if (lt != rt) begin
					chk_err = ERR_TYPE;
				end else if (lt != TAG_INT) begin
					chk_err = ERR_BADOP;
				end else begin
					case (cur_q.opcode)
						OP_ADD:  chk_val = lv + rv;
						OP_SUB:  chk_val = lv - rv;
						OP_MUL:  chk_iter = 1'b1;
						OP_POW: begin
							if (rv[63]) begin
								if (lv == 64'd1) chk_val = 64'd1;
								else if (lv == '1) chk_val = rv[0] ? '1 : 64'd1;
								else chk_val = 64'd0;
							end else begin
								chk_iter = 1'b1;
							end
						end
						default: begin
							if (rv == 64'd0) chk_err = ERR_DIVZ;
							else chk_iter = 1'b1;
						end
					endcase
					if (chk_err == ERR_OK && !chk_iter) begin
						chk_wr  = 1'b1;
						chk_tag = TAG_INT;
						chk_cnt = cnt_m1;
					end
				end
			end
			CLS_CMP: begin
				if (cnt_q < CW'(2)) begin
					chk_err = ERR_FEW;
				end else if (lt != rt) begin
					chk_err = ERR_TYPE;
				end else if (lt != TAG_INT && !(cur_q.opcode == OP_EQ || cur_q.opcode == OP_NE))
				begin
					chk_err = ERR_BADOP;
				end else begin
					case (cur_q.opcode)
						OP_LT:   chk_val = {63'd0, $signed(lv) <  $signed(rv)};
						OP_LE:   chk_val = {63'd0, $signed(lv) <= $signed(rv)};
						OP_EQ:   chk_val = {63'd0, lv == rv};
						OP_NE:   chk_val = {63'd0, lv != rv};
						OP_GE:   chk_val = {63'd0, $signed(lv) >= $signed(rv)};
						default: chk_val = {63'd0, $signed(lv) >  $signed(rv)};
					endcase
					chk_wr  = 1'b1;
					chk_tag = TAG_BOOL;
					chk_cnt = cnt_m1;
				end
			end
			default: chk_err = ERR_BADOP;
		endcase
	end

	// iteration step terms
	assign trial  = {acc_q, a_q[63]} - {1'b0, b_q};
	assign pw_acc = acc_q[31:0] * b_q[31:0];
	assign pw_sq  = b_q[31:0] * b_q[31:0];
	assign iter_last = (cur_q.opcode == OP_POW) ? (ex_q == 64'd0) : (it_q == '1);

	// final value of an iterated operation
	always_comb begin
		case (cur_q.opcode)
			OP_MUL:  fin_val = acc_q;
			OP_DIV:  fin_val = (sa_q != sb_q) ? (64'd0 - a_q) : a_q;
			OP_REM:  fin_val = sa_q ? (64'd0 - acc_q) : acc_q;
			default: fin_val = {{32{acc_q[31]}}, acc_q[31:0]};
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (q_valid) state_nxt = ST_CHECK;
			ST_CHECK: state_nxt = chk_iter ? ST_ITER : ST_IDLE;
			ST_ITER:  if (iter_last) state_nxt = ST_FIN;
			ST_FIN:   state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = chk_waddr;
		mem_wdata = '{tag: chk_tag, value: chk_val};
		emit      = 1'b0;
		emit_err  = chk_err;
		emit_val  = chk_val;
		emit_tag  = chk_tag;
		emit_cnt  = chk_cnt;
		case (state_q)
			ST_IDLE: q_pop = q_valid;
			ST_CHECK: begin
				mem_we = chk_wr;
				emit   = !chk_iter;
			end
			ST_FIN: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_m2[AW-1:0];
				mem_wdata = '{tag: TAG_INT, value: fin_val};
				emit      = 1'b1;
				emit_err  = ERR_OK;
				emit_val  = fin_val;
				emit_tag  = TAG_INT;
				emit_cnt  = cnt_m1;
			end
			default: ;
		endcase
	end

	// item and iteration datapath
	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_item;
		if (state_q == ST_CHECK && chk_iter) begin
			it_q <= '0;
			sa_q <= lv[63];
			sb_q <= rv[63];
			ex_q <= rv;
			case (cur_q.opcode)
				OP_MUL: begin
					a_q <= lv; b_q <= rv; acc_q <= 64'd0;
				end
				OP_POW: begin
					a_q <= 64'd0; b_q <= lv; acc_q <= 64'd1;
				end
				default: begin
					a_q <= ua; b_q <= ub; acc_q <= 64'd0;
				end
			endcase
		end else if (state_q == ST_ITER) begin
			it_q <= it_q + 6'd1;
			case (cur_q.opcode)
				OP_MUL: begin
					if (a_q[0]) acc_q <= acc_q + b_q;
					a_q <= {1'b0, a_q[63:1]};
					b_q <= {b_q[62:0], 1'b0};
				end
				OP_POW: begin
					if (ex_q != 64'd0) begin
						if (ex_q[0]) acc_q <= {32'd0, pw_acc};
						b_q  <= {32'd0, pw_sq};
						ex_q <= {1'b0, ex_q[63:1]};
					end
				end
				default: begin
					if (!trial[64]) acc_q <= trial[63:0];
					else acc_q <= {acc_q[62:0], a_q[63]};
					a_q <= {a_q[62:0], !trial[64]};
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.error_code  <= emit_err;
			result_q.top_value   <= emit_val;
			result_q.top_tag     <= emit_tag;
			result_q.stack_depth <= 7'(emit_cnt);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= emit;
			if (emit) cnt_q <= emit_cnt;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### rtl/tagged_stack_alu.sv
// push, pop, add, sub, compare: queue slot, then item register cur_q, then result register
// mul, div, rem: bit-serial iteration in ST_ITER, then ST_FIN; pow: a square-and-multiply step
// per exponent bit up to the highest one set; the execute unit pops a new item only in ST_IDLE,
// so it finishes each item first; a two-beat queue takes items meanwhile
// results are strobed for one cycle and the receiver cannot stall
// reset: async active low, empties the stack and queue; stack storage itself is not cleared
module tagged_stack_alu #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tsa_pkg::in_item_t   in_item,
	output logic                done,
	output tsa_pkg::out_item_t  result
);
	import tsa_pkg::*;

	logic      q_valid;
	logic      q_pop;
	dec_item_t q_item;

	// decode and queue
	tsa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.in_item (in_item),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// stack and execute
	tsa_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.done    (done),
		.result  (result)
	);

endmodule

### rtl/tsa_checker.sv
`include "tagged_stack_alu_defines.svh"

module tsa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               done,
	input tsa_pkg::out_item_t result
);
	import tsa_pkg::*;

	logic err_beat;
	logic ok_beat;
	logic empty_entry;
	logic legal_tag;

	// beat classes and entry shapes
	assign err_beat    = done && (result.error_code != ERR_OK);
	assign ok_beat     = done && (result.error_code == ERR_OK);
	assign empty_entry = (result.top_value == 64'd0) && (result.top_tag == TAG_NONE);
	assign legal_tag   = (result.top_tag == TAG_INT) || (result.top_tag == TAG_BOOL);

	// error code stays in the defined set
	`TSA_ASSERT_NOW(a_err_range, clk, arst_n, done, result.error_code <= ERR_BADOP)
	// a refused operation shows an empty entry
	`TSA_ASSERT_NOW(a_err_empty, clk, arst_n, err_beat, empty_entry)
	// a good beat carries a legal tag
	`TSA_ASSERT_NOW(a_ok_tag, clk, arst_n, ok_beat, legal_tag)
	// done drops again after each result beat
	`TSA_ASSERT_NEXT(a_done_gap, clk, arst_n, done, !done)

endmodule

bind tagged_stack_alu tsa_checker u_chk (.*);
